// ===== sv/amfs_pkg.sv =====
`timescale 1ns / 1ps
package amfs_pkg;

    localparam int SINCOS_ITERATIONS = 16;
    localparam int SER_STAGES        = 3 * (SINCOS_ITERATIONS - 1);

    localparam logic signed [35:0] TH_PI     = 36'sh0C90FDAA2;
    localparam logic signed [35:0] TH_HALFPI = 36'sh06487ED51;
    localparam logic signed [35:0] TH_TWOPI  = 36'sh1921FB544;
    localparam logic signed [33:0] Q30_ONE   = 34'sh040000000;
    localparam logic [31:0]        Q16_ONE   = 32'h00010000;
    localparam logic [1:0]         ROW_LAST  = 2'd3;

    typedef struct packed {
        logic signed [35:0] th;
        logic               neg_cos;
        logic signed [33:0] x2;
        logic signed [33:0] term_s;
        logic signed [33:0] term_c;
        logic signed [33:0] sum_s;
        logic signed [33:0] sum_c;
        logic signed [67:0] prod_s;
        logic signed [67:0] prod_c;
        logic [33:0]        mag_s;
        logic [33:0]        mag_c;
        logic               neg_s;
        logic               neg_c;
    } lane_t;

    typedef struct packed {
        logic [2:0][15:0] scale;
        logic [2:0][31:0] move;
    } carry_t;

    typedef struct packed {
        carry_t          car;
        lane_t [2:0]     lane;
    } item_t;

    function automatic logic signed [67:0] rnd68(input logic signed [67:0] v,
                                                 input int unsigned s);
        logic [67:0] mag;
        logic [67:0] half;
        begin
            half = 68'd1 << (s - 1);
            mag  = v[67] ? 68'(-v) : 68'(v);
            mag  = (mag + half) >> s;
            rnd68 = v[67] ? -$signed(mag) : $signed(mag);
        end
    endfunction

    function automatic logic signed [31:0] clamp_unit(input logic signed [33:0] v);
        begin
            if (v > Q30_ONE)
                clamp_unit = 32'(Q30_ONE);
            else if (v < -Q30_ONE)
                clamp_unit = 32'(-Q30_ONE);
            else
                clamp_unit = 32'(v);
        end
    endfunction

    function automatic logic signed [33:0] div_fix(input logic signed [67:0] prod,
                                                   input logic [33:0] mag,
                                                   input logic neg,
                                                   input logic [33:0] d);
        logic [33:0] q;
        logic [33:0] qd;
        logic [33:0] rem;
        begin
            q   = 34'(prod[67:33]);
            qd  = 34'(q * d);
            rem = mag - qd;
            if (rem >= d)
                q = q + 34'd1;
            div_fix = neg ? $signed(q) : -$signed(q);
        end
    endfunction

    function automatic item_t step_a(input item_t it);
        item_t o;
        begin
            o = it;
            for (int i = 0; i < 3; i++)
            begin
                o.lane[i].prod_s = it.lane[i].term_s * it.lane[i].x2;
                o.lane[i].prod_c = it.lane[i].term_c * it.lane[i].x2;
            end
            step_a = o;
        end
    endfunction

    function automatic item_t step_b(input item_t it, input logic [33:0] rs,
                                     input logic [33:0] rc);
        item_t o;
        logic signed [67:0] r;
        logic [67:0] pu;
        begin
            o = it;
            for (int i = 0; i < 3; i++)
            begin
                r = rnd68(it.lane[i].prod_s, 30);
                o.lane[i].neg_s  = r[67];
                o.lane[i].mag_s  = 34'(r[67] ? -r : r);
                pu = 68'(o.lane[i].mag_s) * 68'(rs);
                o.lane[i].prod_s = $signed(pu);
                r = rnd68(it.lane[i].prod_c, 30);
                o.lane[i].neg_c  = r[67];
                o.lane[i].mag_c  = 34'(r[67] ? -r : r);
                pu = 68'(o.lane[i].mag_c) * 68'(rc);
                o.lane[i].prod_c = $signed(pu);
            end
            step_b = o;
        end
    endfunction

    function automatic item_t step_c(input item_t it, input logic [33:0] ds,
                                     input logic [33:0] dc);
        item_t o;
        logic signed [33:0] t;
        begin
            o = it;
            for (int i = 0; i < 3; i++)
            begin
                t = div_fix(it.lane[i].prod_s, it.lane[i].mag_s, it.lane[i].neg_s, ds);
                o.lane[i].term_s = t;
                o.lane[i].sum_s  = it.lane[i].sum_s + t;
                t = div_fix(it.lane[i].prod_c, it.lane[i].mag_c, it.lane[i].neg_c, dc);
                o.lane[i].term_c = t;
                o.lane[i].sum_c  = it.lane[i].sum_c + t;
            end
            step_c = o;
        end
    endfunction

endpackage

// ===== sv/affine_matrix_from_srt.sv =====
`timescale 1ns / 1ps
// Affine matrix from scale, Euler rotation and translation.
// Input channel item_valid / item_ready carries one transaction: scale
// (Q8.8), angles in radians (Q3.12) and translation (Q16.16).
// Output channel row_valid / row_ready carries four row transactions per
// input, rows 0 to 3 in order; last_row marks row 3. Rows 0 to 2 hold the
// scaled rotation rows with col3 zero, row 3 the translation and one.
// Row 0 is presented once the input has passed the pre-stages that reduce
// and square the angles, the series pipeline, the matrix stages and the
// output holding register; the remaining rows follow one per cycle while
// row_ready is high. The sustained input rate is set by the single row
// channel that drains four rows per input. The sine and cosine series run
// in a pipeline of three stages per term, so inputs may enter every cycle
// until the output holding register backs up.
// On a stall of row_ready the row is held, the pipeline freezes as a whole
// once its last stage is occupied, and item_ready falls.
// Reset clears all valid bits and the row counter; data registers are not
// reset.
module affine_matrix_from_srt (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic signed [15:0] scale_x,
    input  logic signed [15:0] scale_y,
    input  logic signed [15:0] scale_z,
    input  logic signed [15:0] angle_x,
    input  logic signed [15:0] angle_y,
    input  logic signed [15:0] angle_z,
    input  logic signed [31:0] move_x,
    input  logic signed [31:0] move_y,
    input  logic signed [31:0] move_z,
    output logic               row_valid,
    input  logic               row_ready,
    output logic [1:0]         row_number,
    output logic signed [31:0] col0,
    output logic signed [31:0] col1,
    output logic signed [31:0] col2,
    output logic signed [31:0] col3,
    output logic               last_row
);
    import amfs_pkg::*;

    logic en;
    logic hold_free;
    logic row_take;

    item_t p0_reg, p1_reg, p2_reg;
    item_t p0_next, p1_next, p2_next, s0_next;
    item_t ser_reg [SER_STAGES+1];
    logic [2:0] pre_v_reg;
    logic [SER_STAGES:0] ser_v_reg;

    logic [2:0][15:0] ang;

    logic signed [31:0] sn_reg [3];
    logic signed [31:0] cs_reg [3];
    carry_t f_car_reg, m1_car_reg, m2_car_reg, m3_car_reg, m4_car_reg, m5_car_reg;
    logic [5:0] m_v_reg;

    logic signed [63:0] p_ysc_reg, p_yss_reg, p00_reg, p01_reg, p12_reg, p22_reg;
    logic signed [63:0] p_sxsz_reg, p_cxsz_reg, p_cxcz_reg, p_sxcz_reg;
    logic signed [31:0] m1_sx_reg, m1_cx_reg, m1_sy_reg;

    logic signed [65:0] q_a_reg, q_b_reg, q_c_reg, q_d_reg;
    logic signed [63:0] m2_p00_reg, m2_p01_reg, m2_p12_reg, m2_p22_reg;
    logic signed [63:0] m2_sxsz_reg, m2_cxsz_reg, m2_cxcz_reg, m2_sxcz_reg;
    logic signed [31:0] m2_sy_reg;
    logic signed [33:0] ysc_next, yss_next;

    logic signed [33:0] r_reg [3][3];
    logic signed [49:0] e_reg [3][3];
    logic signed [31:0] el_reg [3][3];
    logic signed [31:0] h_el_reg [3][3];
    logic [2:0][31:0]   h_move_reg;
    logic               hv_reg;
    logic [1:0]         row_reg;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        begin
            if (v > 68'sd2147483647)
                sat32 = 32'sh7FFFFFFF;
            else if (v < -68'sd2147483648)
                sat32 = 32'sh80000000;
            else
                sat32 = v[31:0];
        end
    endfunction

    assign ang = {angle_z, angle_y, angle_x};

    assign row_take  = row_valid && row_ready;
    assign hold_free = !hv_reg || (row_take && row_reg == ROW_LAST);
    assign en        = !m_v_reg[5] || hold_free;
    assign item_ready = en;

    always_comb
    begin
        p0_next = '0;
        p0_next.car.scale = {scale_z, scale_y, scale_x};
        p0_next.car.move  = {move_z, move_y, move_x};
        for (int i = 0; i < 3; i++)
        begin
            p0_next.lane[i].th = {{2{ang[i][15]}}, ang[i], 18'd0};
            if (p0_next.lane[i].th > TH_PI)
                p0_next.lane[i].th = p0_next.lane[i].th - TH_TWOPI;
            if (p0_next.lane[i].th > TH_PI)
                p0_next.lane[i].th = p0_next.lane[i].th - TH_TWOPI;
            if (p0_next.lane[i].th < -TH_PI)
                p0_next.lane[i].th = p0_next.lane[i].th + TH_TWOPI;
            if (p0_next.lane[i].th < -TH_PI)
                p0_next.lane[i].th = p0_next.lane[i].th + TH_TWOPI;
        end
    end

    always_comb
    begin
        p1_next = p0_reg;
        for (int i = 0; i < 3; i++)
        begin
            p1_next.lane[i].neg_cos = 1'b0;
            if (p0_reg.lane[i].th > TH_HALFPI)
            begin
                p1_next.lane[i].th      = TH_PI - p0_reg.lane[i].th;
                p1_next.lane[i].neg_cos = 1'b1;
            end
            else if (p0_reg.lane[i].th < -TH_HALFPI)
            begin
                p1_next.lane[i].th      = -TH_PI - p0_reg.lane[i].th;
                p1_next.lane[i].neg_cos = 1'b1;
            end
            p1_next.lane[i].term_s = 34'(p1_next.lane[i].th);
        end
    end

    always_comb
    begin
        p2_next = p1_reg;
        for (int i = 0; i < 3; i++)
            p2_next.lane[i].prod_s = p1_reg.lane[i].term_s * p1_reg.lane[i].term_s;
    end

    always_comb
    begin
        s0_next = p2_reg;
        for (int i = 0; i < 3; i++)
        begin
            s0_next.lane[i].x2     = 34'(rnd68(p2_reg.lane[i].prod_s, 30));
            s0_next.lane[i].sum_s  = p2_reg.lane[i].term_s;
            s0_next.lane[i].term_c = Q30_ONE;
            s0_next.lane[i].sum_c  = Q30_ONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg     <= p0_next;
            p1_reg     <= p1_next;
            p2_reg     <= p2_next;
            ser_reg[0] <= s0_next;
        end
    end

    for (genvar gk = 1; gk < SINCOS_ITERATIONS; gk++)
    begin : g_term
        localparam logic [33:0] DS = 34'((2 * gk) * (2 * gk + 1));
        localparam logic [33:0] DC = 34'((2 * gk - 1) * (2 * gk));
        localparam logic [33:0] RS = 34'((64'd1 << 33) / DS);
        localparam logic [33:0] RC = 34'((64'd1 << 33) / DC);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ser_reg[3*gk-2] <= step_a(ser_reg[3*gk-3]);
                ser_reg[3*gk-1] <= step_b(ser_reg[3*gk-2], RS, RC);
                ser_reg[3*gk]   <= step_c(ser_reg[3*gk-1], DS, DC);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_v_reg <= '0;
            ser_v_reg <= '0;
            m_v_reg   <= '0;
        end
        else if (en)
        begin
            pre_v_reg <= {pre_v_reg[1:0], item_valid};
            ser_v_reg <= {ser_v_reg[SER_STAGES-1:0], pre_v_reg[2]};
            m_v_reg   <= {m_v_reg[4:0], ser_v_reg[SER_STAGES]};
        end
    end

    assign ysc_next = 34'(rnd68(68'(p_ysc_reg), 30));
    assign yss_next = 34'(rnd68(68'(p_yss_reg), 30));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sn_reg[i] <= clamp_unit(ser_reg[SER_STAGES].lane[i].sum_s);
                cs_reg[i] <= ser_reg[SER_STAGES].lane[i].neg_cos
                             ? -clamp_unit(ser_reg[SER_STAGES].lane[i].sum_c)
                             : clamp_unit(ser_reg[SER_STAGES].lane[i].sum_c);
            end
            f_car_reg <= ser_reg[SER_STAGES].car;

            p_ysc_reg  <= sn_reg[1] * cs_reg[2];
            p_yss_reg  <= sn_reg[1] * sn_reg[2];
            p00_reg    <= cs_reg[1] * cs_reg[2];
            p01_reg    <= cs_reg[1] * sn_reg[2];
            p12_reg    <= sn_reg[0] * cs_reg[1];
            p22_reg    <= cs_reg[0] * cs_reg[1];
            p_sxsz_reg <= sn_reg[0] * sn_reg[2];
            p_cxsz_reg <= cs_reg[0] * sn_reg[2];
            p_cxcz_reg <= cs_reg[0] * cs_reg[2];
            p_sxcz_reg <= sn_reg[0] * cs_reg[2];
            m1_sx_reg  <= sn_reg[0];
            m1_cx_reg  <= cs_reg[0];
            m1_sy_reg  <= sn_reg[1];
            m1_car_reg <= f_car_reg;

            q_a_reg     <= m1_sx_reg * ysc_next;
            q_b_reg     <= m1_sx_reg * yss_next;
            q_c_reg     <= m1_cx_reg * ysc_next;
            q_d_reg     <= m1_cx_reg * yss_next;
            m2_p00_reg  <= p00_reg;
            m2_p01_reg  <= p01_reg;
            m2_p12_reg  <= p12_reg;
            m2_p22_reg  <= p22_reg;
            m2_sxsz_reg <= p_sxsz_reg;
            m2_cxsz_reg <= p_cxsz_reg;
            m2_cxcz_reg <= p_cxcz_reg;
            m2_sxcz_reg <= p_sxcz_reg;
            m2_sy_reg   <= m1_sy_reg;
            m2_car_reg  <= m1_car_reg;

            r_reg[0][0] <= 34'(rnd68(68'(m2_p00_reg), 30));
            r_reg[0][1] <= 34'(rnd68(68'(m2_p01_reg), 30));
            r_reg[0][2] <= -34'(m2_sy_reg);
            r_reg[1][0] <= 34'(rnd68(68'(q_a_reg) - 68'(m2_cxsz_reg), 30));
            r_reg[1][1] <= 34'(rnd68(68'(m2_cxcz_reg) + 68'(q_b_reg), 30));
            r_reg[1][2] <= 34'(rnd68(68'(m2_p12_reg), 30));
            r_reg[2][0] <= 34'(rnd68(68'(m2_sxsz_reg) + 68'(q_c_reg), 30));
            r_reg[2][1] <= 34'(rnd68(68'(q_d_reg) - 68'(m2_sxcz_reg), 30));
            r_reg[2][2] <= 34'(rnd68(68'(m2_p22_reg), 30));
            m3_car_reg  <= m2_car_reg;

            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    e_reg[i][j] <= $signed(m3_car_reg.scale[i]) * r_reg[i][j];
            m4_car_reg <= m3_car_reg;

            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    el_reg[i][j] <= sat32(rnd68(68'(e_reg[i][j]), 22));
            m5_car_reg <= m4_car_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hv_reg  <= 1'b0;
            row_reg <= 2'd0;
        end
        else if (hold_free)
        begin
            hv_reg  <= m_v_reg[5];
            row_reg <= 2'd0;
        end
        else if (row_take)
        begin
            row_reg <= row_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold_free)
        begin
            h_el_reg   <= el_reg;
            h_move_reg <= m5_car_reg.move;
        end
    end

    assign row_valid  = hv_reg;
    assign row_number = row_reg;
    assign last_row   = (row_reg == ROW_LAST);

    always_comb
    begin
        case (row_reg)
            2'd0:
            begin
                col0 = h_el_reg[0][0];
                col1 = h_el_reg[0][1];
                col2 = h_el_reg[0][2];
                col3 = '0;
            end
            2'd1:
            begin
                col0 = h_el_reg[1][0];
                col1 = h_el_reg[1][1];
                col2 = h_el_reg[1][2];
                col3 = '0;
            end
            2'd2:
            begin
                col0 = h_el_reg[2][0];
                col1 = h_el_reg[2][1];
                col2 = h_el_reg[2][2];
                col3 = '0;
            end
            default:
            begin
                col0 = $signed(h_move_reg[0]);
                col1 = $signed(h_move_reg[1]);
                col2 = $signed(h_move_reg[2]);
                col3 = $signed(Q16_ONE);
            end
        endcase
    end

    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        row_take && !last_row |=> row_valid && row_number == $past(row_number) + 2'd1)
        else $error("row sequence broken");

    a_row_start: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && row_number != 2'd0 |-> $past(row_valid))
        else $error("row shown without its predecessor");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && !row_ready && m_v_reg[5] |-> !item_ready)
        else $error("input taken while pipeline is blocked");

endmodule
